### rtl/core/bmc_pkg.sv
`default_nettype none
package bmc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH  = 1024;
  localparam int ADDR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);
  localparam int OPEN_DEPTH_W = 11;
  localparam int KIND_W       = 2;

  // Verdict codes
  localparam logic [2:0] V_PENDING  = 3'd0;
  localparam logic [2:0] V_REJECT   = 3'd1;
  localparam logic [2:0] V_ACCEPT   = 3'd2;
  localparam logic [2:0] V_SILENT   = 3'd3;
  localparam logic [2:0] V_OVERFLOW = 3'd4;
  localparam logic [2:0] V_NONE     = 3'd0;

  // Bracket kind codes
  localparam logic [KIND_W-1:0] KIND_T    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_1    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_2    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Character codes
  localparam logic [7:0] CH_OPEN_T  = 8'h54;  // 'T'
  localparam logic [7:0] CH_OPEN_1  = 8'h31;  // '1'
  localparam logic [7:0] CH_OPEN_2  = 8'h32;  // '2'
  localparam logic [7:0] CH_CLOSE_C = 8'h43;  // 'C'
  localparam logic [7:0] CH_CLOSE_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_CLOSE_0 = 8'h30;  // '0'

  // Checker state held between characters
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               matched;
    logic [2:0]         failed;
    logic [KIND_W-1:0]  top;
  } bmc_state_t;

  // Stack write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] data;
  } bmc_wr_t;

  // One result item
  typedef struct packed {
    logic [OPEN_DEPTH_W-1:0] open_depth;
    logic [2:0]              verdict;
    logic                    final_item;
  } bmc_result_t;

endpackage
`default_nettype wire

### rtl/core/bmc_ram.sv
`default_nettype none
module bmc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/bmc_step.sv
`default_nettype none
module bmc_step
  import bmc_pkg::*;
(
  input  wire logic [7:0]        char_code,
  input  wire logic              is_last,
  input  wire bmc_state_t        state,
  input  wire logic [KIND_W-1:0] under,    // entry just below the stack top
  output bmc_state_t             state_nxt,
  output bmc_wr_t                wr,
  output bmc_result_t            result
);

  logic [KIND_W-1:0]                 open_kind;
  logic [KIND_W-1:0]                 close_kind;
  bmc_state_t                        proc;
  logic [2:0]                        verdict;
  logic [DEPTH_W+OPEN_DEPTH_W-1:0]   depth_ext;

  // Decode the character into opener and closer kinds
  always_comb begin
    case (char_code)
      CH_OPEN_T: open_kind = KIND_T;
      CH_OPEN_1: open_kind = KIND_1;
      CH_OPEN_2: open_kind = KIND_2;
      default:   open_kind = KIND_NONE;
    endcase
    case (char_code)
      CH_CLOSE_C: close_kind = KIND_T;
      CH_CLOSE_9: close_kind = KIND_1;
      CH_CLOSE_0: close_kind = KIND_2;
      default:    close_kind = KIND_NONE;
    endcase
  end

  // Push, pop or fail; nothing moves once a failure is recorded
  always_comb begin
    proc    = state;
    wr.en   = 1'b0;
    wr.addr = state.depth[ADDR_W-1:0];
    wr.data = open_kind;
    if (state.failed == V_NONE) begin
      if (open_kind != KIND_NONE) begin
        if (state.depth == DEPTH_W'(STACK_DEPTH)) begin
          proc.failed = V_OVERFLOW;
        end else begin
          wr.en      = 1'b1;
          proc.depth = state.depth + DEPTH_W'(1);
          proc.top   = open_kind;
        end
      end else if (state.depth == '0) begin
        proc.failed = V_REJECT;
      end else if (close_kind != KIND_NONE) begin
        proc.depth = state.depth - DEPTH_W'(1);
        proc.top   = under;
        if (state.top != close_kind) begin
          proc.failed = V_REJECT;
        end else begin
          proc.matched = 1'b1;
        end
      end
    end
  end

  // Verdict and end-of-string clearing
  always_comb begin
    if (proc.failed != V_NONE) begin
      verdict = proc.failed;
    end else if (!is_last) begin
      verdict = V_PENDING;
    end else if (proc.matched) begin
      verdict = V_ACCEPT;
    end else begin
      verdict = V_SILENT;
    end

    depth_ext         = {{OPEN_DEPTH_W{1'b0}}, proc.depth};
    result.open_depth = depth_ext[OPEN_DEPTH_W-1:0];
    result.verdict    = verdict;
    result.final_item = is_last;

    state_nxt = proc;
    if (is_last) begin
      state_nxt.depth   = '0;
      state_nxt.matched = 1'b0;
      state_nxt.failed  = V_NONE;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bmc_out_stage.sv
`default_nettype none
module bmc_out_stage
  import bmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire bmc_result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bmc_result_t      out_data
);

  logic        out_v_r;
  logic        skid_v_r;
  bmc_result_t out_r;
  bmc_result_t skid_r;

  assign can_push  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Control: output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule
`default_nettype wire

### rtl/core/three_kind_bracket_match_checker.sv
// Results are registered in the output stage. Throughput: one character per cycle
// while in_tready is high; the stack top and the entry below it are kept ready (top
// in a register, next entry from the RAM's registered read port). Reset: synchronous
// active-low rst_n clears depth, match and failure state and the output stage; the
// stack RAM is not cleared, no clearing pass is needed.
`default_nettype none
module three_kind_bracket_match_checker
  import bmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] verdict, [13:3] open_depth, [15:14] zero
  output logic             out_tlast   // final_item
);

  bmc_state_t        state_r;
  bmc_state_t        state_step;
  bmc_state_t        state_nxt;
  bmc_wr_t           wr;
  bmc_result_t       step_result;
  bmc_result_t       out_result;
  logic [KIND_W-1:0] under;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;

  assign accept = in_tvalid && in_tready;

  // Next-state and result logic for one character
  bmc_step u_step (
    .char_code (in_tdata),
    .is_last   (in_tlast),
    .state     (state_r),
    .under     (under),
    .state_nxt (state_step),
    .wr        (wr),
    .result    (step_result)
  );

  assign state_nxt = accept ? state_step : state_r;

  // State registers (top entry has no reset: only read once pushed)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.depth   <= '0;
      state_r.matched <= 1'b0;
      state_r.failed  <= V_NONE;
    end else begin
      state_r.depth   <= state_nxt.depth;
      state_r.matched <= state_nxt.matched;
      state_r.failed  <= state_nxt.failed;
    end
    state_r.top <= state_nxt.top;
  end

  // Prefetch the entry below the next top
  assign rd_addr = ADDR_W'(state_nxt.depth - DEPTH_W'(2));

  bmc_ram #(
    .WIDTH (KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (wr.en && accept),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (under)
  );

  // Result register with skid entry
  bmc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_result),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  assign out_tdata = {2'b00, out_result.open_depth, out_result.verdict};
  assign out_tlast = out_result.final_item;

endmodule
`default_nettype wire
